>>> hdl/cidv_pkg.sv
// ----------------------------------------------------------------------------
// cidv_pkg
// shared types, constants and the saturating counter increment of the binary content identifier validator
// ----------------------------------------------------------------------------
package cidv_pkg;

	localparam int MAX_ID_BYTES = 255;
	localparam int CNT_W = $clog2(MAX_ID_BYTES + 2);

	localparam logic [2:0] FIELD_VERSION = 3'd0;
	localparam logic [2:0] FIELD_CODEC   = 3'd1;
	localparam logic [2:0] FIELD_HASH    = 3'd2;
	localparam logic [2:0] FIELD_DLEN    = 3'd3;
	localparam logic [2:0] FIELD_DIGEST  = 3'd4;

	localparam logic [7:0] LEGACY_BYTE0  = 8'h12;
	localparam logic [7:0] LEGACY_BYTE1  = 8'h20;
	localparam int         LEGACY_LEN    = 34;

	localparam logic [7:0] CONT_MASK     = 8'h80;
	localparam logic [7:0] VALUE_MASK    = 8'h7f;
	localparam logic [7:0] OVF_MASK      = 8'h7e;
	localparam logic [3:0] VARINT_MAX    = 4'd10;
	localparam logic [6:0] LAST_SHIFT    = 7'd63;

	typedef struct packed {
		logic [2:0]       field;
		logic [63:0]      accum;
		logic [3:0]       vbytes;
		logic [63:0]      dlen;
		logic [CNT_W-1:0] pcount;
		logic             failed;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		field:  FIELD_VERSION,
		accum:  64'd0,
		vbytes: 4'd0,
		dlen:   64'd0,
		pcount: '0,
		failed: 1'b0
	};

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = (v > CNT_W'(MAX_ID_BYTES)) ? v : v + CNT_W'(1);
		return r;
	endfunction

endpackage

>>> hdl/cidv_in_if.sv
// ----------------------------------------------------------------------------
// cidv_in_if
// byte channel: one identifier byte per transaction with a last flag
// ----------------------------------------------------------------------------
interface cidv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hdl/cidv_out_if.sv
// ----------------------------------------------------------------------------
// cidv_out_if
// verdict channel: one verdict per identifier
// ----------------------------------------------------------------------------
interface cidv_out_if;
	logic valid;
	logic ready;
	logic cid_ok;
	logic legacy_form;

	modport source (output valid, output cid_ok, output legacy_form, input ready);
	modport sink (input valid, input cid_ok, input legacy_form, output ready);
endinterface

>>> hdl/cidv_header_parser.sv
// ----------------------------------------------------------------------------
// cidv_header_parser
// next-state logic of the varint header parse and the digest byte count for one byte
// ----------------------------------------------------------------------------
module cidv_header_parser (
	input  logic [7:0]            data_byte,
	input  cidv_pkg::parse_state_t cur,
	output cidv_pkg::parse_state_t nxt
);
	import cidv_pkg::*;

	logic [6:0]  shift;
	logic [69:0] wide;
	logic [63:0] acc_new;
	logic [3:0]  vb_inc;

	always_comb begin
		shift   = 7'(cur.vbytes) * 7'd7;
		wide    = 70'(data_byte & VALUE_MASK) << shift;
		acc_new = cur.accum | wide[63:0];
		vb_inc  = cur.vbytes + 4'd1;
		nxt     = cur;
		if (!cur.failed) begin
			if (cur.field == FIELD_DIGEST) begin
				nxt.pcount = sat_inc(cur.pcount);
			end else if (shift == LAST_SHIFT && (data_byte & OVF_MASK) != 8'd0) begin
				nxt.failed = 1'b1;
			end else begin
				nxt.accum = acc_new;
				if ((data_byte & CONT_MASK) == 8'd0) begin
					if (cur.vbytes != 4'd0 && data_byte == 8'd0) begin
						nxt.failed = 1'b1;
					end else begin
						if (cur.field == FIELD_VERSION && acc_new != 64'd1) begin
							nxt.failed = 1'b1;
						end else if ((cur.field == FIELD_CODEC || cur.field == FIELD_HASH)
						             && acc_new == 64'd0) begin
							nxt.failed = 1'b1;
						end else if (cur.field == FIELD_DLEN) begin
							nxt.dlen = acc_new;
						end
						nxt.field  = cur.field + 3'd1;
						nxt.accum  = 64'd0;
						nxt.vbytes = 4'd0;
					end
				end else begin
					nxt.vbytes = vb_inc;
					if (vb_inc >= VARINT_MAX) begin
						nxt.failed = 1'b1;
					end
				end
			end
		end
	end
endmodule

>>> hdl/cid_binary_validator.sv
// ----------------------------------------------------------------------------
// cid_binary_validator
// validates binary content identifiers streamed one byte per transaction
// ----------------------------------------------------------------------------
// verdict path: the last byte passes the input register, then the result register drives verdict valid
// throughput: one byte per cycle, set by the input register and the parse step
// a verdict waiting in the output register stalls only a following last byte
// reset: arst_n clears parse state, counters and the valid flags of both registers at once
module cid_binary_validator (
	input logic        clk,
	input logic        arst_n,
	cidv_in_if.sink    byte_stream,
	cidv_out_if.source verdict
);
	import cidv_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	parse_state_t     pstate_q;
	parse_state_t     pstate_nxt;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] total_nxt;
	logic             prefix_q;
	logic             prefix_nxt;

	logic             out_valid_q;
	logic             ok_q;
	logic             legacy_q;

	logic             advance;
	logic             step;
	logic             too_long;
	logic             legacy_hit;
	logic             ok_nxt;
	logic             legacy_nxt;

	cidv_header_parser u_parser (
		.data_byte (byte_s1),
		.cur       (pstate_q),
		.nxt       (pstate_nxt)
	);

	assign advance = !(last_s1 && out_valid_q && !verdict.ready);
	assign step    = valid_s1 && advance;
	assign byte_stream.ready = !valid_s1 || advance;

	always_comb begin
		prefix_nxt = prefix_q;
		if (total_q == CNT_W'(0) && byte_s1 != LEGACY_BYTE0) begin
			prefix_nxt = 1'b0;
		end
		if (total_q == CNT_W'(1) && byte_s1 != LEGACY_BYTE1) begin
			prefix_nxt = 1'b0;
		end
		total_nxt  = sat_inc(total_q);
		too_long   = total_nxt > CNT_W'(MAX_ID_BYTES);
		legacy_hit = total_nxt == CNT_W'(LEGACY_LEN) && prefix_nxt;
		ok_nxt     = !too_long && (legacy_hit || (!pstate_nxt.failed
		             && pstate_nxt.field == FIELD_DIGEST
		             && pstate_nxt.dlen == 64'(pstate_nxt.pcount)));
		legacy_nxt = !too_long && legacy_hit;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.ready && byte_stream.valid) begin
			byte_s1 <= byte_stream.data_byte;
			last_s1 <= byte_stream.last_byte;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstate_q <= PARSE_RESET;
			total_q  <= '0;
			prefix_q <= 1'b1;
		end else if (step) begin
			if (last_s1) begin
				pstate_q <= PARSE_RESET;
				total_q  <= '0;
				prefix_q <= 1'b1;
			end else begin
				pstate_q <= pstate_nxt;
				total_q  <= total_nxt;
				prefix_q <= prefix_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			ok_q     <= ok_nxt;
			legacy_q <= legacy_nxt;
		end
	end

	assign verdict.valid       = out_valid_q;
	assign verdict.cid_ok      = ok_q;
	assign verdict.legacy_form = legacy_q;

`ifndef SYNTHESIS
	a_legacy_ok : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!legacy_q || ok_q))
		else $error("legacy form flagged without a valid verdict");

	a_last_gives_verdict : assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> out_valid_q)
		else $error("last byte did not produce a verdict");

	a_varint_bound : assert property (@(posedge clk) disable iff (!arst_n)
		!pstate_q.failed |-> (pstate_q.vbytes < VARINT_MAX
		&& pstate_q.field <= FIELD_DIGEST))
		else $error("varint parse out of range without failure");

	a_count_sat : assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_ID_BYTES + 1) && pstate_q.pcount <= total_q)
		else $error("byte counters beyond saturation");

	a_stall_holds : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && last_s1 && $stable(byte_s1)))
		else $error("stalled last byte lost");
`endif
endmodule

>>> dv/cidv_verdict_checker.sv
// ----------------------------------------------------------------------------
// cidv_verdict_checker
// watches both channels of the identifier validator, keeps its own copy of
// the parse state, works out the verdict due for every last byte and compares
// each verdict transaction with the oldest one due
// ----------------------------------------------------------------------------
module cidv_verdict_checker (
	input  logic clk,
	input  logic arst_n,
	cidv_in_if   byte_stream,
	cidv_out_if  verdict,
	output int   errors,
	output int   pending
);
	import cidv_pkg::*;

	typedef struct packed {
		logic ok;
		logic legacy;
	} verdict_t;

	verdict_t verdicts_due[$];
	verdict_t want;

	logic [2:0]       field_r;
	logic [63:0]      accum_r;
	logic [3:0]       vbytes_r;
	logic [63:0]      dlen_r;
	logic [CNT_W-1:0] pcount_r;
	logic [CNT_W-1:0] tcount_r;
	logic             prefix_r;
	logic             failed_r;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic clear_parse();
		field_r  = FIELD_VERSION;
		accum_r  = '0;
		vbytes_r = '0;
		dlen_r   = '0;
		pcount_r = '0;
		tcount_r = '0;
		prefix_r = 1'b1;
		failed_r = 1'b0;
	endtask

	task automatic take_varint(input logic [7:0] b);
		logic [6:0] sh;
		sh = 7'(7 * vbytes_r);
		if (sh == LAST_SHIFT && (b & OVF_MASK) != 8'h00) begin
			failed_r = 1'b1;
		end else begin
			accum_r |= 64'(b & VALUE_MASK) << sh;
			if ((b & CONT_MASK) == 8'h00) begin
				if (vbytes_r != 4'd0 && b == 8'h00) begin
					failed_r = 1'b1;
				end else begin
					if (field_r == FIELD_VERSION && accum_r != 64'd1)
						failed_r = 1'b1;
					else if ((field_r == FIELD_CODEC || field_r == FIELD_HASH) &&
							accum_r == 64'd0)
						failed_r = 1'b1;
					else if (field_r == FIELD_DLEN)
						dlen_r = accum_r;
					field_r++;
					accum_r  = '0;
					vbytes_r = '0;
				end
			end else begin
				vbytes_r++;
				if (vbytes_r >= VARINT_MAX)
					failed_r = 1'b1;
			end
		end
	endtask

	task automatic take_byte(input logic [7:0] b, input logic lst);
		verdict_t v;
		if (tcount_r == 0 && b != LEGACY_BYTE0)
			prefix_r = 1'b0;
		if (tcount_r == 1 && b != LEGACY_BYTE1)
			prefix_r = 1'b0;
		if (tcount_r <= MAX_ID_BYTES)
			tcount_r++;
		if (!failed_r) begin
			if (field_r >= FIELD_DIGEST) begin
				if (pcount_r <= MAX_ID_BYTES)
					pcount_r++;
			end else begin
				take_varint(b);
			end
		end
		if (lst) begin
			v.legacy = 1'b0;
			if (tcount_r > MAX_ID_BYTES) begin
				v.ok = 1'b0;
			end else if (tcount_r == LEGACY_LEN && prefix_r) begin
				v.ok     = 1'b1;
				v.legacy = 1'b1;
			end else begin
				v.ok = !failed_r && field_r == FIELD_DIGEST && dlen_r == 64'(pcount_r);
			end
			verdicts_due.push_back(v);
			clear_parse();
		end
	endtask

	initial begin
		errors  = 0;
		pending = 0;
		clear_parse();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
		end else begin
			if (verdict.valid && verdict.ready) begin
				if (verdicts_due.size() == 0) begin
					report($sformatf("verdict ok=%0b legacy=%0b with none due",
						verdict.cid_ok, verdict.legacy_form));
				end else begin
					want = verdicts_due.pop_front();
					if (verdict.cid_ok !== want.ok)
						report($sformatf("cid_ok got %0b want %0b",
							verdict.cid_ok, want.ok));
					if (verdict.legacy_form !== want.legacy)
						report($sformatf("legacy_form got %0b want %0b",
							verdict.legacy_form, want.legacy));
				end
			end
			if (byte_stream.valid && byte_stream.ready)
				take_byte(byte_stream.data_byte, byte_stream.last_byte);
			pending <= verdicts_due.size();
		end
	end

endmodule

>>> dv/cid_binary_validator_tb.sv
// ----------------------------------------------------------------------------
// cid_binary_validator_tb
// streams directed and random identifiers into the validator with random
// gaps and verdict stalls; the checker beside the block compares verdicts
// ----------------------------------------------------------------------------
module cid_binary_validator_tb;
	import cidv_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TOTAL_BYTES = 1450;

	logic clk = 1'b0;
	logic arst_n;
	logic quiet;

	int errors;
	int pending;
	int cycle_count;
	int bytes_sent;
	int ids_sent;
	int sink_wait;
	int sink_gap;

	logic [7:0] id_bytes[$];

	cidv_in_if  byte_stream ();
	cidv_out_if verdict ();

	cid_binary_validator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.verdict     (verdict)
	);

	cidv_verdict_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.verdict     (verdict),
		.errors      (errors),
		.pending     (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int idle_gap(input int busy);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 100 - busy)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict.ready <= 1'b0;
			sink_wait = 0;
		end else if (sink_wait > 0) begin
			sink_wait--;
			verdict.ready <= 1'b0;
		end else begin
			sink_gap = idle_gap(35);
			if (sink_gap == 0) begin
				verdict.ready <= 1'b1;
			end else begin
				verdict.ready <= 1'b0;
				sink_wait = sink_gap - 1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cid_binary_validator test failed");
		$finish;
	end

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0: v = 64'($urandom_range(1, 127));
			1: v = 64'($urandom_range(128, 16383));
			2: v = 64'($urandom_range(16384, 32'h0fff_ffff));
			default: v = {$urandom, $urandom};
		endcase
		if (v == 64'd0)
			v = 64'd1;
		return v;
	endfunction

	task automatic push_varint(input logic [63:0] v);
		logic [63:0] rest;
		rest = v;
		do begin
			id_bytes.push_back({rest > 64'd127, rest[6:0]});
			rest = rest >> 7;
		end while (rest != 64'd0);
	endtask

	task automatic push_header(input logic [63:0] ver, input logic [63:0] codec,
			input logic [63:0] hash, input logic [63:0] dlen);
		push_varint(ver);
		push_varint(codec);
		push_varint(hash);
		push_varint(dlen);
	endtask

	task automatic push_fill(input int n, input logic [7:0] b);
		repeat (n) id_bytes.push_back(b);
	endtask

	task automatic push_random(input int n);
		repeat (n) id_bytes.push_back(8'($urandom));
	endtask

	task automatic trim_to(input int keep);
		while (id_bytes.size() > keep)
			void'(id_bytes.pop_back());
	endtask

	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = idle_gap(40);
		if (gap > 0) begin
			byte_stream.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_stream.valid     <= 1'b1;
		byte_stream.data_byte <= b;
		byte_stream.last_byte <= lst;
		do @(posedge clk); while (!byte_stream.ready);
	endtask

	task automatic send_id();
		int n;
		n = id_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(id_bytes[i], i == n - 1);
		bytes_sent += n;
		ids_sent++;
		id_bytes.delete();
	endtask

	task automatic drain();
		byte_stream.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_directed();
		// header cut short after one byte
		id_bytes.push_back(8'h01);
		send_id();
		push_header(1, 1, 1, 0);
		send_id();
		push_header(0, 1, 1, 0);
		send_id();
		push_header(1, 0, 1, 0);
		send_id();
		push_header(1, 1, 0, 0);
		send_id();
		// legacy form and near misses
		id_bytes.push_back(LEGACY_BYTE0);
		id_bytes.push_back(LEGACY_BYTE1);
		push_fill(32, 8'hff);
		send_id();
		id_bytes.push_back(LEGACY_BYTE0);
		id_bytes.push_back(LEGACY_BYTE1);
		push_fill(31, 8'h00);
		send_id();
		push_header(1, 64'h70, 64'h12, 30);
		push_fill(30, 8'h00);
		send_id();
		// varint ending in a zero byte
		push_fill(1, 8'h01);
		push_fill(1, 8'h81);
		push_fill(1, 8'h00);
		push_fill(1, 8'h01);
		push_fill(1, 8'h00);
		send_id();
		push_header(1, 64'hffff_ffff_ffff_ffff, 1, 0);
		send_id();
		// tenth byte overflowing 64 bits
		push_fill(1, 8'h01);
		push_fill(9, 8'hff);
		push_fill(1, 8'h02);
		push_fill(1, 8'h01);
		push_fill(1, 8'h00);
		send_id();
		// tenth byte still continuing
		push_fill(1, 8'h01);
		push_fill(10, 8'h80);
		push_fill(1, 8'h01);
		push_fill(1, 8'h01);
		push_fill(1, 8'h00);
		send_id();
		// longest allowed, one too long, and far too long
		push_header(1, 1, 1, 250);
		push_random(250);
		send_id();
		push_header(1, 1, 1, 251);
		push_random(251);
		send_id();
		push_random(300);
		send_id();
		push_header(1, 1, 1, 2);
		push_fill(1, 8'haa);
		send_id();
		push_header(1, 1, 1, 1);
		push_fill(1, 8'h00);
		send_id();
	endtask

	task automatic random_id();
		int len;
		int digest;
		int mut;
		int n;
		case ($urandom_range(0, 99)) inside
			[0:54]: begin
				len    = $urandom_range(0, 24);
				mut    = $urandom_range(0, 11);
				digest = len;
				if (mut == 0)
					digest = len + 1;
				else if (mut == 1)
					digest = (len > 0) ? len - 1 : 2;
				push_header(1, random_value(), random_value(), 64'(len));
				push_random(digest);
				if (mut == 2) begin
					n = $urandom_range(0, id_bytes.size() - 1);
					id_bytes[n] ^= 8'($urandom_range(1, 255));
				end else if (mut == 3) begin
					trim_to($urandom_range(1, id_bytes.size()));
				end
			end
			[55:69]: begin
				id_bytes.push_back(LEGACY_BYTE0);
				id_bytes.push_back(LEGACY_BYTE1);
				push_random(32);
				case ($urandom_range(0, 7))
					0: push_random(1);
					1: void'(id_bytes.pop_back());
					2: id_bytes[1] ^= 8'($urandom_range(1, 255));
					3: id_bytes[0] = 8'h01;
					default: ;
				endcase
			end
			[70:79]: begin
				len = $urandom_range(0, 8);
				case ($urandom_range(0, 3))
					0: begin
						push_varint(1);
						repeat (9) id_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
						case ($urandom_range(0, 4))
							0: id_bytes.push_back(8'h00);
							1: id_bytes.push_back(8'h01);
							2: id_bytes.push_back(8'($urandom_range(2, 127)));
							3: id_bytes.push_back(8'h80);
							default: id_bytes.push_back(8'h81);
						endcase
						push_varint(random_value());
						push_varint(64'(len));
					end
					1: begin
						push_varint(1);
						id_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
						id_bytes.push_back(8'h00);
						push_varint(random_value());
						push_varint(64'(len));
					end
					2: begin
						push_header(($urandom_range(0, 1)) ? 64'd0 : random_value() + 64'd1,
							random_value(), random_value(), 64'(len));
					end
					default: begin
						push_header(1, random_value(), random_value(),
							{$urandom, $urandom} | 64'h8000_0000_0000_0000);
					end
				endcase
				push_random(len);
			end
			[80:94]: begin
				push_random($urandom_range(1, 12));
				if ($urandom_range(0, 1))
					id_bytes[0] = 8'h01;
			end
			[95:97]: begin
				push_header(1, random_value(), random_value(),
					64'($urandom_range(0, 300)));
				trim_to($urandom_range(1, id_bytes.size() - 1));
			end
			default: begin
				len = $urandom_range(240, 262);
				push_header(1, 1, 1, 64'(len));
				push_random(len);
			end
		endcase
		send_id();
	endtask

	initial begin
		arst_n                = 1'b0;
		quiet                 = 1'b0;
		bytes_sent            = 0;
		ids_sent              = 0;
		byte_stream.valid     = 1'b0;
		byte_stream.data_byte = 8'h00;
		byte_stream.last_byte = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain();

		ids_sent = 0;
		while (bytes_sent < TOTAL_BYTES) begin
			quiet <= (ids_sent >= 3 && ids_sent < 8);
			if (ids_sent == 10)
				drain();
			random_id();
		end

		drain();
		repeat (10) @(posedge clk);
		@(negedge clk);
		if (errors == 0) begin
			$display("cid_binary_validator test passed");
		end else begin
			$display("cid_binary_validator test failed");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/cidv_pkg.sv
hdl/cidv_in_if.sv
hdl/cidv_out_if.sv
hdl/cidv_header_parser.sv
hdl/cid_binary_validator.sv
dv/cidv_verdict_checker.sv
dv/cid_binary_validator_tb.sv
